// ----- sv/ir_pulse_distance_transmitter_core_macros.svh -----
// ----------------------------------------------------------------------------
// ir pulse-distance transmitter assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_DISTANCE_TRANSMITTER_CORE_MACROS_SVH
`define IR_PULSE_DISTANCE_TRANSMITTER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define IRPDT_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("irpdt assertion failed");

// antecedent implies consequent in the next cycle
`define IRPDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("irpdt assertion failed");

`endif

// ----- sv/irpdt_pkg.sv -----
// ----------------------------------------------------------------------------
// irpdt_pkg
// shared types, constants and helpers of the ir pulse-distance transmitter
// ----------------------------------------------------------------------------
package irpdt_pkg;

  localparam int FRAME_WIDTH = 64;
  localparam int BIT_IDX_W   = $clog2(FRAME_WIDTH);
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;

  localparam logic [7:0] START_BYTE = 8'd49;

  localparam logic [8:0] RST_LEADER_MARK  = 9'd450;
  localparam logic [8:0] RST_LEADER_SPACE = 9'd157;
  localparam logic [8:0] RST_MARK         = 9'd28;
  localparam logic [8:0] RST_ZERO_SPACE   = 9'd14;
  localparam logic [8:0] RST_ONE_SPACE    = 9'd63;
  localparam logic [FRAME_WIDTH-1:0] RST_FRAME_WORD = FRAME_WIDTH'(64'd8060445446);
  localparam logic [6:0] RST_FRAME_LENGTH = 7'd33;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEADER_MARK  = 3'd0,
    CFG_LEADER_SPACE = 3'd1,
    CFG_MARK         = 3'd2,
    CFG_ZERO_SPACE   = 3'd3,
    CFG_ONE_SPACE    = 3'd4,
    CFG_FRAME_WORD   = 3'd5,
    CFG_FRAME_LENGTH = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [8:0]             leader_mark_cycles;
    logic [8:0]             leader_space_units;
    logic [8:0]             mark_cycles;
    logic [8:0]             zero_space_units;
    logic [8:0]             one_space_units;
    logic [FRAME_WIDTH-1:0] frame_word;
    logic [6:0]             frame_length;
  } cfg_t;

  typedef struct packed {
    logic frame_done;
    logic busy_res;
    logic led_level;
  } res_t;

  // a burst of c carrier cycles, zero counted as one
  function automatic logic [9:0] burst_ticks(input logic [8:0] c);
    burst_ticks = (c == 9'd0) ? 10'd2 : {c, 1'b0};
  endfunction

endpackage

// ----- sv/irpdt_engine.sv -----
// ----------------------------------------------------------------------------
// irpdt_engine
// frame sequencer: one tick or write beat in, one result out, same cycle
// ----------------------------------------------------------------------------
module irpdt_engine
  import irpdt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       req_type,
  input  logic [7:0] write_byte,
  input  cfg_t       cfg,
  output res_t       res
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_LEAD_MARK, PH_LEAD_SPACE, PH_BIT_MARK, PH_BIT_SPACE, PH_TRAIL
  } phase_t;

  phase_t     phase, phase_next;
  logic [9:0] tick_count, tick_count_next;
  logic [6:0] bit_index, bit_index_next;

  logic [6:0] n_bits;
  logic [6:0] bit_inc;
  logic       cur_bit;
  logic [8:0] bit_space;
  logic [9:0] cur_ticks;
  logic [9:0] tick_inc;
  logic       is_mark;
  phase_t     after_bits, after_inc;

  always_comb begin
    n_bits    = (cfg.frame_length > 7'(FRAME_WIDTH)) ? 7'(FRAME_WIDTH) : cfg.frame_length;
    bit_inc   = bit_index + 7'd1;
    cur_bit   = cfg.frame_word[bit_index[BIT_IDX_W-1:0]];
    bit_space = cur_bit ? cfg.one_space_units : cfg.zero_space_units;
    tick_inc  = tick_count + 10'd1;
    is_mark   = (phase == PH_LEAD_MARK) || (phase == PH_BIT_MARK) || (phase == PH_TRAIL);
    after_bits = (bit_index < n_bits) ? PH_BIT_MARK : PH_TRAIL;
    after_inc  = (bit_inc < n_bits) ? PH_BIT_MARK : PH_TRAIL;
    case (phase)
      PH_LEAD_MARK:  cur_ticks = burst_ticks(cfg.leader_mark_cycles);
      PH_LEAD_SPACE: cur_ticks = {cfg.leader_space_units, 1'b0};
      PH_BIT_MARK:   cur_ticks = burst_ticks(cfg.mark_cycles);
      PH_BIT_SPACE:  cur_ticks = {bit_space, 1'b0};
      PH_TRAIL:      cur_ticks = burst_ticks(cfg.mark_cycles);
      default:       cur_ticks = 10'd0;
    endcase
  end

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    bit_index_next  = bit_index;
    res             = '0;
    if (step && req_type) begin
      if (phase == PH_IDLE && write_byte == START_BYTE) begin
        phase_next      = PH_LEAD_MARK;
        tick_count_next = 10'd0;
        bit_index_next  = 7'd0;
      end
      res.busy_res = (phase_next != PH_IDLE);
    end else if (step && phase != PH_IDLE) begin
      res.busy_res    = 1'b1;
      res.led_level   = is_mark && !tick_count[0];
      tick_count_next = tick_inc;
      if (tick_inc >= cur_ticks) begin
        tick_count_next = 10'd0;
        case (phase)
          PH_LEAD_MARK: begin
            // empty leader space is skipped
            phase_next = (cfg.leader_space_units == 9'd0) ? after_bits : PH_LEAD_SPACE;
          end
          PH_LEAD_SPACE: phase_next = after_bits;
          PH_BIT_MARK: begin
            if (bit_space == 9'd0) begin
              bit_index_next = bit_inc;
              phase_next     = after_inc;
            end else begin
              phase_next = PH_BIT_SPACE;
            end
          end
          PH_BIT_SPACE: begin
            bit_index_next = bit_inc;
            phase_next     = after_inc;
          end
          default: begin
            phase_next     = PH_IDLE;
            bit_index_next = 7'd0;
            res.frame_done = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= 10'd0;
      bit_index  <= 7'd0;
    end else begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      bit_index  <= bit_index_next;
    end
  end

endmodule

// ----- sv/irpdt_obuf.sv -----
// ----------------------------------------------------------------------------
// irpdt_obuf
// result register with skid stage
// ----------------------------------------------------------------------------
module irpdt_obuf
  import irpdt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  output logic space,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic out_vld;
  logic skid_vld;
  res_t skid_data;
  logic load;

  assign load      = !out_vld || out_ready;
  assign space     = !skid_vld;
  assign out_valid = out_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (load) begin
      out_vld  <= skid_vld || push;
      skid_vld <= 1'b0;
    end else if (push) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= skid_vld ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ----- sv/ir_pulse_distance_transmitter_core.sv -----
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter_core
// pulse-distance infrared frame transmitter driven by half-carrier ticks
// ----------------------------------------------------------------------------
//   channel  direction  contents
//   s_axis   in         tuser req_type, tdata write_byte
//   m_axis   out        tdata led_level, busy_res; tlast frame_done
//   cfg      in         write enable, register index, 64-bit data
//
// one beat per cycle unless stalled: sequencer finishes a beat in the cycle it is taken
// one result beat per input beat, held in a result register and a skid stage
// s_axis_tready drops only when both result stages are full
// rst is synchronous; it restores the default frame timing and code
// ----------------------------------------------------------------------------
module ir_pulse_distance_transmitter_core
  import irpdt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] write_byte
  input  logic                  s_axis_tuser,   // [0] req_type
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // [0] led_level, [1] busy_res, [7:2] zero
  output logic                  m_axis_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  res_t step_res;
  res_t out_res;
  logic step;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.leader_mark_cycles <= RST_LEADER_MARK;
      cfg.leader_space_units <= RST_LEADER_SPACE;
      cfg.mark_cycles        <= RST_MARK;
      cfg.zero_space_units   <= RST_ZERO_SPACE;
      cfg.one_space_units    <= RST_ONE_SPACE;
      cfg.frame_word         <= RST_FRAME_WORD;
      cfg.frame_length       <= RST_FRAME_LENGTH;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEADER_MARK:  cfg.leader_mark_cycles <= cfg_data[8:0];
        CFG_LEADER_SPACE: cfg.leader_space_units <= cfg_data[8:0];
        CFG_MARK:         cfg.mark_cycles        <= cfg_data[8:0];
        CFG_ZERO_SPACE:   cfg.zero_space_units   <= cfg_data[8:0];
        CFG_ONE_SPACE:    cfg.one_space_units    <= cfg_data[8:0];
        CFG_FRAME_WORD:   cfg.frame_word         <= cfg_data[FRAME_WIDTH-1:0];
        CFG_FRAME_LENGTH: cfg.frame_length       <= cfg_data[6:0];
        default:          ;
      endcase
    end
  end

  assign step = s_axis_tvalid && s_axis_tready;

  irpdt_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .req_type   (s_axis_tuser),
    .write_byte (s_axis_tdata),
    .cfg        (cfg),
    .res        (step_res)
  );

  irpdt_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_data (step_res),
    .space     (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign m_axis_tdata = {6'd0, out_res.busy_res, out_res.led_level};
  assign m_axis_tlast = out_res.frame_done;

endmodule

// ----- sv/irpdt_checker.sv -----
// ----------------------------------------------------------------------------
// irpdt_checker
// port-level checks on the transmitter result stream
// ----------------------------------------------------------------------------
`include "ir_pulse_distance_transmitter_core_macros.svh"

module irpdt_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  `IRPDT_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  `IRPDT_ASSERT_SAME(a_led_busy, clk, rst, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[1])
  `IRPDT_ASSERT_SAME(a_done_dark, clk, rst, m_axis_tvalid && m_axis_tlast, m_axis_tdata[1] && !m_axis_tdata[0])
  `IRPDT_ASSERT_SAME(a_pad_zero, clk, rst, m_axis_tvalid, m_axis_tdata[7:2] == 6'd0)

endmodule

bind ir_pulse_distance_transmitter_core irpdt_checker u_irpdt_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
